/* hw/rtl/tts_pkg.sv */
// Package of shared types and constants for the TFTP transfer sequencer.
`default_nettype none

package tts_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT_CHUNK,
		PH_WAIT_REPLY,
		PH_WAIT_WRITE,
		PH_DONE
	} phase_t;

	localparam logic [2:0] OP_START        = 3'd0;
	localparam logic [2:0] OP_CHUNK_READ   = 3'd1;
	localparam logic [2:0] OP_PACKET       = 3'd2;
	localparam logic [2:0] OP_TIMER        = 3'd3;
	localparam logic [2:0] OP_WRITE_RESULT = 3'd4;

	localparam logic [2:0] SK_NONE  = 3'd0;
	localparam logic [2:0] SK_DATA  = 3'd1;
	localparam logic [2:0] SK_ACK   = 3'd2;
	localparam logic [2:0] SK_OACK  = 3'd3;
	localparam logic [2:0] SK_ERROR = 3'd4;

	localparam logic [2:0] ST_RUNNING     = 3'd0;
	localparam logic [2:0] ST_SUCCESS     = 3'd1;
	localparam logic [2:0] ST_LOCAL_ERROR = 3'd2;
	localparam logic [2:0] ST_TIMEOUT     = 3'd3;
	localparam logic [2:0] ST_PEER_ERROR  = 3'd4;

	localparam logic [3:0] ERR_UNDEFINED = 4'd0;
	localparam logic [3:0] ERR_NOT_FOUND = 4'd1;
	localparam logic [3:0] ERR_DISK_FULL = 4'd3;

	localparam logic [15:0] OPC_DATA  = 16'd3;
	localparam logic [15:0] OPC_ACK   = 16'd4;
	localparam logic [15:0] OPC_ERROR = 16'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_DIRECTION = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_OPTION_ACK      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_TIMEOUT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_STEP    = 3'd5;

	localparam logic [15:0] RST_BLOCK_SIZE      = 16'd512;
	localparam logic [7:0]  RST_RETRY_LIMIT     = 8'd12;
	localparam logic [15:0] RST_INITIAL_TIMEOUT = 16'd100;
	localparam logic [15:0] RST_TIMEOUT_STEP    = 16'd150;

	typedef struct packed {
		logic        write_direction;
		logic [15:0] block_size;
		logic        option_ack;
		logic [7:0]  retry_limit;
		logic [15:0] initial_timeout;
		logic [15:0] timeout_step;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic        open_failed;
		logic [15:0] chunk_length;
		logic        read_failed;
		logic [15:0] packet_opcode;
		logic [15:0] packet_block;
		logic [15:0] payload_length;
		logic        packet_short;
		logic        write_ok;
	} item_t;

	typedef struct packed {
		logic [2:0]  send_kind;
		logic [15:0] send_block;
		logic [15:0] send_length;
		logic [3:0]  error_code;
		logic        fetch_chunk;
		logic        store_payload;
		logic [15:0] store_length;
		logic        arm_timer;
		logic [15:0] timer_value;
		logic        finished;
		logic [2:0]  status;
		logic [15:0] peer_error;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/tts_cfg_regs.sv */
// Configuration register file of the TFTP transfer sequencer.
`default_nettype none

module tts_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tts_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tts_pkg::cfg_t                         cfg
);

	tts_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_direction <= 1'b0;
			cfg_q.block_size      <= tts_pkg::RST_BLOCK_SIZE;
			cfg_q.option_ack      <= 1'b0;
			cfg_q.retry_limit     <= tts_pkg::RST_RETRY_LIMIT;
			cfg_q.initial_timeout <= tts_pkg::RST_INITIAL_TIMEOUT;
			cfg_q.timeout_step    <= tts_pkg::RST_TIMEOUT_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tts_pkg::CFG_WRITE_DIRECTION: cfg_q.write_direction <= cfg_data[0];
				tts_pkg::CFG_BLOCK_SIZE:      cfg_q.block_size      <= cfg_data;
				tts_pkg::CFG_OPTION_ACK:      cfg_q.option_ack      <= cfg_data[0];
				tts_pkg::CFG_RETRY_LIMIT:     cfg_q.retry_limit     <= cfg_data[7:0];
				tts_pkg::CFG_INITIAL_TIMEOUT: cfg_q.initial_timeout <= cfg_data;
				tts_pkg::CFG_TIMEOUT_STEP:    cfg_q.timeout_step    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tts_engine.sv */
// Transfer state registers and the per-event decision logic.
`default_nettype none

module tts_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tts_pkg::cfg_t   cfg,
	input  wire logic            step,
	input  wire tts_pkg::item_t  item,
	output tts_pkg::result_t     res
);

	tts_pkg::phase_t phase_q, phase_d;
	logic [15:0] next_block_q, next_block_d;
	logic        last_q, last_d;
	logic [7:0]  retries_q, retries_d;
	logic [15:0] wait_q, wait_d;
	logic [2:0]  sent_kind_q, sent_kind_d;
	logic [15:0] sent_block_q, sent_block_d;
	logic [15:0] sent_length_q, sent_length_d;
	logic [15:0] pending_q, pending_d;

	logic [15:0] chunk_len;
	logic [15:0] pay_len;
	logic [16:0] wait_sum;
	logic [15:0] wait_grown;
	logic [15:0] prev_block;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= tts_pkg::PH_IDLE;
			next_block_q  <= 16'd1;
			last_q        <= 1'b0;
			retries_q     <= tts_pkg::RST_RETRY_LIMIT;
			wait_q        <= tts_pkg::RST_INITIAL_TIMEOUT;
			sent_kind_q   <= tts_pkg::SK_NONE;
			sent_block_q  <= 16'd0;
			sent_length_q <= 16'd0;
			pending_q     <= 16'd0;
		end else if (step) begin
			phase_q       <= phase_d;
			next_block_q  <= next_block_d;
			last_q        <= last_d;
			retries_q     <= retries_d;
			wait_q        <= wait_d;
			sent_kind_q   <= sent_kind_d;
			sent_block_q  <= sent_block_d;
			sent_length_q <= sent_length_d;
			pending_q     <= pending_d;
		end
	end

	assign chunk_len  = (item.chunk_length > cfg.block_size) ? cfg.block_size
	                                                          : item.chunk_length;
	assign pay_len    = (item.payload_length > cfg.block_size) ? cfg.block_size
	                                                            : item.payload_length;
	assign wait_sum   = {1'b0, wait_q} + {1'b0, cfg.timeout_step};
	assign wait_grown = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
	assign prev_block = next_block_q - 16'd1;

	always_comb begin
		res           = '0;
		phase_d       = phase_q;
		next_block_d  = next_block_q;
		last_d        = last_q;
		retries_d     = retries_q;
		wait_d        = wait_q;
		sent_kind_d   = sent_kind_q;
		sent_block_d  = sent_block_q;
		sent_length_d = sent_length_q;
		pending_d     = pending_q;

		case (item.operation)
			tts_pkg::OP_START: begin
				next_block_d = 16'd1;
				last_d       = 1'b0;
				pending_d    = 16'd0;
				if (item.open_failed) begin
					res.send_kind  = tts_pkg::SK_ERROR;
					res.error_code = tts_pkg::ERR_NOT_FOUND;
					res.finished   = 1'b1;
					res.status     = tts_pkg::ST_LOCAL_ERROR;
					phase_d        = tts_pkg::PH_DONE;
				end else if (cfg.option_ack || cfg.write_direction) begin
					sent_kind_d     = cfg.option_ack ? tts_pkg::SK_OACK : tts_pkg::SK_ACK;
					sent_block_d    = 16'd0;
					sent_length_d   = 16'd0;
					retries_d       = cfg.retry_limit;
					wait_d          = cfg.initial_timeout;
					res.send_kind   = sent_kind_d;
					res.arm_timer   = 1'b1;
					res.timer_value = cfg.initial_timeout;
					phase_d         = tts_pkg::PH_WAIT_REPLY;
				end else begin
					res.fetch_chunk = 1'b1;
					phase_d         = tts_pkg::PH_WAIT_CHUNK;
				end
			end
			tts_pkg::OP_CHUNK_READ: begin
				if (phase_q == tts_pkg::PH_WAIT_CHUNK) begin
					if (item.read_failed) begin
						res.send_kind  = tts_pkg::SK_ERROR;
						res.error_code = tts_pkg::ERR_UNDEFINED;
						res.finished   = 1'b1;
						res.status     = tts_pkg::ST_LOCAL_ERROR;
						phase_d        = tts_pkg::PH_DONE;
					end else begin
						last_d          = (chunk_len != cfg.block_size);
						sent_kind_d     = tts_pkg::SK_DATA;
						sent_block_d    = next_block_q;
						sent_length_d   = chunk_len;
						retries_d       = cfg.retry_limit;
						wait_d          = cfg.initial_timeout;
						res.send_kind   = tts_pkg::SK_DATA;
						res.send_block  = next_block_q;
						res.send_length = chunk_len;
						res.arm_timer   = 1'b1;
						res.timer_value = cfg.initial_timeout;
						phase_d         = tts_pkg::PH_WAIT_REPLY;
						next_block_d    = next_block_q + 16'd1;
					end
				end
			end
			tts_pkg::OP_PACKET: begin
				if (phase_q == tts_pkg::PH_WAIT_REPLY) begin
					if (item.packet_short) begin
						res.arm_timer   = 1'b1;
						res.timer_value = wait_q;
					end else if (item.packet_opcode == tts_pkg::OPC_ERROR) begin
						res.peer_error = item.packet_block;
						res.finished   = 1'b1;
						res.status     = tts_pkg::ST_PEER_ERROR;
						phase_d        = tts_pkg::PH_DONE;
					end else if (!cfg.write_direction &&
					             item.packet_opcode == tts_pkg::OPC_ACK &&
					             item.packet_block == prev_block) begin
						if (last_q) begin
							res.finished = 1'b1;
							res.status   = tts_pkg::ST_SUCCESS;
							phase_d      = tts_pkg::PH_DONE;
						end else begin
							res.fetch_chunk = 1'b1;
							phase_d         = tts_pkg::PH_WAIT_CHUNK;
						end
					end else if (cfg.write_direction &&
					             item.packet_opcode == tts_pkg::OPC_DATA) begin
						if (item.packet_block == next_block_q) begin
							pending_d         = pay_len;
							res.store_payload = 1'b1;
							res.store_length  = pay_len;
							phase_d           = tts_pkg::PH_WAIT_WRITE;
						end else begin
							res.send_kind   = sent_kind_q;
							res.send_block  = sent_block_q;
							res.send_length = sent_length_q;
							res.arm_timer   = 1'b1;
							res.timer_value = wait_q;
						end
					end else begin
						res.arm_timer   = 1'b1;
						res.timer_value = wait_q;
					end
				end
			end
			tts_pkg::OP_TIMER: begin
				if (phase_q == tts_pkg::PH_WAIT_REPLY) begin
					if (retries_q <= 8'd1) begin
						retries_d    = 8'd0;
						res.finished = 1'b1;
						res.status   = tts_pkg::ST_TIMEOUT;
						phase_d      = tts_pkg::PH_DONE;
					end else begin
						retries_d       = retries_q - 8'd1;
						wait_d          = wait_grown;
						res.send_kind   = sent_kind_q;
						res.send_block  = sent_block_q;
						res.send_length = sent_length_q;
						res.arm_timer   = 1'b1;
						res.timer_value = wait_grown;
					end
				end
			end
			tts_pkg::OP_WRITE_RESULT: begin
				if (phase_q == tts_pkg::PH_WAIT_WRITE) begin
					if (!item.write_ok) begin
						res.send_kind  = tts_pkg::SK_ERROR;
						res.error_code = tts_pkg::ERR_DISK_FULL;
						res.finished   = 1'b1;
						res.status     = tts_pkg::ST_LOCAL_ERROR;
						phase_d        = tts_pkg::PH_DONE;
					end else begin
						last_d         = (pending_q != cfg.block_size);
						sent_kind_d    = tts_pkg::SK_ACK;
						sent_block_d   = next_block_q;
						sent_length_d  = 16'd0;
						retries_d      = cfg.retry_limit;
						wait_d         = cfg.initial_timeout;
						res.send_kind  = tts_pkg::SK_ACK;
						res.send_block = next_block_q;
						next_block_d   = next_block_q + 16'd1;
						if (pending_q != cfg.block_size) begin
							res.finished = 1'b1;
							res.status   = tts_pkg::ST_SUCCESS;
							phase_d      = tts_pkg::PH_DONE;
						end else begin
							res.arm_timer   = 1'b1;
							res.timer_value = cfg.initial_timeout;
							phase_d         = tts_pkg::PH_WAIT_REPLY;
						end
					end
				end
			end
			default: ;
		endcase
	end

	a_status_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.finished == (res.status != tts_pkg::ST_RUNNING))
		else $error("status and finished disagree");

	a_fetch_enters_wait_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.fetch_chunk |=> phase_q == tts_pkg::PH_WAIT_CHUNK)
		else $error("chunk request without waiting for chunk");

	a_timer_means_wait_reply: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.arm_timer |=> phase_q == tts_pkg::PH_WAIT_REPLY)
		else $error("timer armed outside reply wait");

	a_finish_enters_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.finished |=> phase_q == tts_pkg::PH_DONE)
		else $error("transfer ended without done phase");

endmodule

`default_nettype wire

/* hw/rtl/tftp_transfer_sequencer.sv */
// Top level of the TFTP transfer sequencer: input register, engine, result register.
//
// Each event word yields exactly one result word. It is first held in the
// input register; the decision logic then writes the result register and
// the transfer state at the same edge, once the result is free. A new event
// word is taken every cycle while results are taken; a result held by a low
// out_ready stalls the input register, and in_ready drops once both
// registers are full. Configuration writes are accepted every cycle.
`default_nettype none

module tftp_transfer_sequencer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [tts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [2:0]                       operation,
	input  wire logic                             open_failed,
	input  wire logic [15:0]                      chunk_length,
	input  wire logic                             read_failed,
	input  wire logic [15:0]                      packet_opcode,
	input  wire logic [15:0]                      packet_block,
	input  wire logic [15:0]                      payload_length,
	input  wire logic                             packet_short,
	input  wire logic                             write_ok,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [2:0]                            send_kind,
	output logic [15:0]                           send_block,
	output logic [15:0]                           send_length,
	output logic [3:0]                            error_code,
	output logic                                  fetch_chunk,
	output logic                                  store_payload,
	output logic [15:0]                           store_length,
	output logic                                  arm_timer,
	output logic [15:0]                           timer_value,
	output logic                                  finished,
	output logic [2:0]                            status,
	output logic [15:0]                           peer_error
);

	tts_pkg::cfg_t    cfg;
	tts_pkg::item_t   item_in;
	tts_pkg::item_t   item_s1;
	logic             valid_s1;
	tts_pkg::result_t res;
	tts_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;

	tts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign item_in.operation      = operation;
	assign item_in.open_failed    = open_failed;
	assign item_in.chunk_length   = chunk_length;
	assign item_in.read_failed    = read_failed;
	assign item_in.packet_opcode  = packet_opcode;
	assign item_in.packet_block   = packet_block;
	assign item_in.payload_length = payload_length;
	assign item_in.packet_short   = packet_short;
	assign item_in.write_ok       = write_ok;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

	tts_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign send_kind     = res_q.send_kind;
	assign send_block    = res_q.send_block;
	assign send_length   = res_q.send_length;
	assign error_code    = res_q.error_code;
	assign fetch_chunk   = res_q.fetch_chunk;
	assign store_payload = res_q.store_payload;
	assign store_length  = res_q.store_length;
	assign arm_timer     = res_q.arm_timer;
	assign timer_value   = res_q.timer_value;
	assign finished      = res_q.finished;
	assign status        = res_q.status;
	assign peer_error    = res_q.peer_error;

	a_stalled_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled event word lost");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("pending result word changed");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

`default_nettype wire
